>>> rtl/ewi_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the encoder window indicator
// no dependencies; imported by every module of the block

package ewi_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int POS_WIDTH   = 32;
    localparam int KEY_WIDTH   = 4;
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;

    localparam logic [KEY_WIDTH-1:0] DIGIT_LIMIT = KEY_WIDTH'(10);
    localparam logic [COUNT_WIDTH-1:0] COUNT_SIGN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_KEY    = 2'd0,
        CMD_RISE   = 2'd1,
        CMD_FALL   = 2'd2,
        CMD_BUTTON = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_LOW   = 2'd0,
        MODE_HIGH  = 2'd1,
        MODE_TRACK = 2'd2
    } t_mode;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        t_cmd                 cmd;
        logic [KEY_WIDTH-1:0] key_code;
        logic                 dt_level;
    } t_event;

    typedef struct packed {
        logic                        red_on;
        logic                        blue_on;
        t_mode                       mode_now;
        logic signed [POS_WIDTH-1:0] position;
    } t_result;

endpackage

>>> rtl/ewi_in_stage.sv
`timescale 1ns / 1ps
// input register of the encoder window indicator: unpacks and holds one event
// depends on ewi_pkg

module ewi_in_stage
    import ewi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic                 i_take,
    output logic                 o_valid,
    output t_event               o_event
);

    logic   r_valid;
    t_event r_event;
    t_event n_event;

    assign o_s_tready = !r_valid || i_take;

    always_comb begin
        n_event.cmd      = t_cmd'(i_s_tuser);
        n_event.key_code = i_s_tdata[KEY_WIDTH-1:0];
        n_event.dt_level = i_s_tdata[KEY_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_event <= n_event;
        end
    end

    assign o_valid = r_valid;
    assign o_event = r_event;

endmodule

>>> rtl/ewi_core.sv
`timescale 1ns / 1ps
// mode, limit and position state with the window check and the result register
// depends on ewi_pkg

module ewi_core
    import ewi_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_event i_event,
    output logic   o_take,
    output logic   o_valid,
    input  logic   i_ready,
    output t_result o_result
);

    t_mode                r_mode;
    t_mode                n_mode;
    logic [KEY_WIDTH-1:0] r_low;
    logic [KEY_WIDTH-1:0] n_low;
    logic [KEY_WIDTH-1:0] r_high;
    logic [KEY_WIDTH-1:0] n_high;
    t_count               r_count;
    t_count               n_count;
    logic [1:0]           r_lamp;
    logic [1:0]           n_lamp;
    logic                 r_out_valid;
    t_result              r_out;
    t_result              n_out;

    logic   is_digit;
    logic   step_up;
    logic   neg;
    t_count mag;
    logic   in_window;
    logic   advance;

    assign o_take  = !r_out_valid || i_ready;
    assign advance = i_valid && o_take;

    assign is_digit = (i_event.key_code != '0) && (i_event.key_code < DIGIT_LIMIT);
    // rising edge: dt low counts up; falling edge: dt high counts up
    assign step_up  = (i_event.cmd == CMD_RISE) ? !i_event.dt_level : i_event.dt_level;

    // window check on the stepped count
    always_comb begin
        n_count   = step_up ? r_count + 1'b1 : r_count - 1'b1;
        neg       = n_count[COUNT_WIDTH-1];
        mag       = neg ? (~n_count + 1'b1) : n_count;
        in_window = !(neg && (mag == COUNT_SIGN))
                 && (mag >= COUNT_WIDTH'(r_low))
                 && (mag <= COUNT_WIDTH'(r_high));
    end

    always_comb begin
        n_mode  = r_mode;
        n_low   = r_low;
        n_high  = r_high;
        n_lamp  = r_lamp;
        case (i_event.cmd)
            CMD_KEY: begin
                if (is_digit && r_mode == MODE_LOW) begin
                    n_low  = i_event.key_code;
                    n_mode = MODE_HIGH;
                end else if (is_digit && r_mode == MODE_HIGH && i_event.key_code >= r_low) begin
                    n_high = i_event.key_code;
                    n_mode = MODE_TRACK;
                end
            end
            CMD_RISE, CMD_FALL: begin
                if (r_mode == MODE_TRACK) begin
                    if (!in_window) begin
                        n_lamp = 2'b00;
                    end else if (!neg && n_count != '0) begin
                        n_lamp = 2'b01;
                    end else begin
                        n_lamp = 2'b10;
                    end
                end
            end
            default: begin
                n_lamp = 2'b00;
                n_mode = MODE_LOW;
            end
        endcase
    end

    always_comb begin
        n_out.red_on   = n_lamp[0];
        n_out.blue_on  = n_lamp[1];
        n_out.mode_now = n_mode;
        if (i_event.cmd == CMD_BUTTON) begin
            n_out.position = '0;
        end else if ((i_event.cmd == CMD_RISE || i_event.cmd == CMD_FALL)
                     && r_mode == MODE_TRACK) begin
            n_out.position = POS_WIDTH'(signed'(n_count));
        end else begin
            n_out.position = POS_WIDTH'(signed'(r_count));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LOW;
            r_low       <= '0;
            r_high      <= '0;
            r_count     <= '0;
            r_lamp      <= 2'b00;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_mode <= n_mode;
                r_low  <= n_low;
                r_high <= n_high;
                r_lamp <= n_lamp;
                if (i_event.cmd == CMD_BUTTON) begin
                    r_count <= '0;
                end else if ((i_event.cmd == CMD_RISE || i_event.cmd == CMD_FALL)
                             && r_mode == MODE_TRACK) begin
                    r_count <= n_count;
                end
            end
            if (o_take) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> rtl/encoder_window_indicator.sv
`timescale 1ns / 1ps
// Encoder window indicator top level.
// Slave channel: one event per item; tuser carries the event kind
// (key press, clock rising edge, clock falling edge, button), tdata the key
// code and the DT level. Master channel: one result per item with both LED
// states, the current mode and the signed net position.
// Keys 1-9 set the low then the high limit; after that, encoder edges move
// a wrapping position and the LEDs show whether its magnitude lies in the
// window (red positive, blue zero or negative). The button clears position
// and LEDs and returns to limit entry, keeping the limits.
// An accepted item passes the input register, then the state update into
// the result register. One item per cycle while the receiver does not
// stall; the increment and window compare on the position register are
// combinational.
// Reset (synchronous, active low) clears mode, limits, position, LEDs and
// both stage valids. When the receiver stalls, the result register holds,
// the input register fills, and o_s_tready drops until the result is taken.
// depends on ewi_pkg, ewi_in_stage, ewi_core

module encoder_window_indicator
    import ewi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // key_code[3:0], dt_level[4], zero pad
    input  logic [S_TUSER_W-1:0] i_s_tuser,  // cmd[1:0]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // red_on[0], blue_on[1], mode_now[3:2],
                                             // position[35:4], zero pad
);

    logic    take;
    logic    ev_valid;
    t_event  ev;
    t_result res;

    ewi_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_take     (take),
        .o_valid    (ev_valid),
        .o_event    (ev)
    );

    ewi_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (ev_valid),
        .i_event  (ev),
        .o_take   (take),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (res)
    );

    assign o_m_tdata = {
        (M_TDATA_W-POS_WIDTH-4)'(0),
        res.position,
        res.mode_now,
        res.blue_on,
        res.red_on
    };

endmodule

>>> rtl/ewi_checker.sv
`timescale 1ns / 1ps
// port-level checks for the encoder window indicator, bound to the top level
// depends on ewi_pkg and encoder_window_indicator

module ewi_checker
    import ewi_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [S_TDATA_W-1:0] i_s_tdata,
    input logic [S_TUSER_W-1:0] i_s_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    logic  red;
    logic  blue;
    t_mode mode;
    logic signed [POS_WIDTH-1:0] pos;

    assign red  = o_m_tdata[0];
    assign blue = o_m_tdata[1];
    assign mode = t_mode'(o_m_tdata[3:2]);
    assign pos  = o_m_tdata[POS_WIDTH+3:4];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a waiting input item is held by the sender until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=> i_s_tvalid && $stable(i_s_tdata) && $stable(i_s_tuser))
        else $error("input item changed while waiting");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // red means a strictly positive position
    a_red_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && red |-> !blue && pos > 0)
        else $error("red lit with non-positive position");

    // before tracking starts the position and LEDs stay cleared
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && mode != MODE_TRACK |-> !red && !blue && pos == 0)
        else $error("position or LEDs set outside tracking");

endmodule

bind encoder_window_indicator ewi_checker u_ewi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
